// File: hdl/clnf_pkg.sv
// Shared types and constants for the character-LCD number formatter.
// No dependencies; imported by every module of the block.
package clnf_pkg;

	typedef struct packed {
		logic [2:0]  operation;
		logic [1:0]  line;
		logic [5:0]  column;
		logic [15:0] value;
		logic [4:0]  digit_count;
	} in_item_t;

	typedef struct packed {
		logic       is_data;
		logic [7:0] bus_byte;
		logic       last;
	} out_item_t;

	typedef logic [1:0] base_t;

	localparam logic [2:0] OP_RAW  = 3'd0;
	localparam logic [2:0] OP_UDEC = 3'd1;
	localparam logic [2:0] OP_SDEC = 3'd2;
	localparam logic [2:0] OP_HEX  = 3'd3;
	localparam logic [2:0] OP_BIN  = 3'd4;

	localparam base_t BASE_DEC = 2'd0;
	localparam base_t BASE_HEX = 2'd1;
	localparam base_t BASE_BIN = 2'd2;

	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [7:0] LINE2_OFFSET = 8'h40;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;

	// Multiply-shift reciprocal of ten, exact for every 16-bit dividend.
	localparam logic [15:0] RECIP_TEN = 16'd52429;
	localparam int          RECIP_SHIFT = 19;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		if (d < 4'd10) begin
			digit_char = CHAR_ZERO + {4'd0, d};
		end else begin
			digit_char = CHAR_UPPER_A + {4'd0, d} - 8'd10;
		end
	endfunction

endpackage

// File: hdl/clnf_digit_unit.sv
// Shared digit extractor: one divide step by 10, 16 or 2 per cycle.
// Depends on clnf_pkg.
module clnf_digit_unit (
	input  logic [15:0]          dividend,
	input  clnf_pkg::base_t      base,
	output logic [15:0]          quotient,
	output logic [3:0]           remainder
);
	import clnf_pkg::*;

	logic [31:0] prod;
	logic [15:0] q_dec;
	logic [15:0] q_times_ten;

	assign prod        = {16'd0, dividend} * {16'd0, RECIP_TEN};
	assign q_dec       = 16'(prod[31:RECIP_SHIFT]);
	assign q_times_ten = (q_dec << 3) + (q_dec << 1);

	always_comb begin
		case (base)
			BASE_DEC: begin
				quotient  = q_dec;
				remainder = 4'(dividend - q_times_ten);
			end
			BASE_HEX: begin
				quotient  = {4'd0, dividend[15:4]};
				remainder = dividend[3:0];
			end
			BASE_BIN: begin
				quotient  = {1'b0, dividend[15:1]};
				remainder = {3'd0, dividend[0]};
			end
			default: begin
				quotient  = 16'd0;
				remainder = 4'd0;
			end
		endcase
	end

endmodule

// File: hdl/char_lcd_number_formatter_top.sv
// Top level of the character-LCD number formatter: sequencer, digit store
// and output register. Depends on clnf_pkg and clnf_digit_unit.
//
//   channel | signals                        | direction
//   in      | in_valid, in_stall, in_item    | request item into block
//   out     | out_valid, out_stall, out_item | bus-write items out of block
//
// An item is accepted; the shared divide unit then extracts each shown digit,
// one more step leaves that loop, and the bus writes follow in order: the
// command, the sign or raw character where the operation has one, the digits.
// in_stall stays high from acceptance until the last write is loaded.
// out_stall holds the output register and freezes the sequencer in its write states.
// Reset clears the sequencer and the output valid flag.
module char_lcd_number_formatter_top #(
	parameter int MAX_DIGITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  clnf_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output clnf_pkg::out_item_t  out_item
);
	import clnf_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_CMD  = 3'd2;
	localparam logic [2:0] S_RAW  = 3'd3;
	localparam logic [2:0] S_SIGN = 3'd4;
	localparam logic [2:0] S_DIG  = 3'd5;

	logic [2:0]       state_q;
	logic [2:0]       op_q;
	logic [7:0]       addr_q;
	logic [15:0]      val_q;
	logic             neg_q;
	base_t            base_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] k_q;
	logic [3:0]       digits_q [MAX_DIGITS];

	logic             out_valid_q;
	out_item_t        out_q;

	logic [15:0]      quot;
	logic [3:0]       rem;
	logic             can_load;
	logic             accept;
	logic [5:0]       cnt_sat;
	logic [CNT_W-1:0] km1;
	logic [7:0]       addr_calc;
	logic             op_digits;
	logic             emitting;
	logic             cmd_only;

	clnf_digit_unit u_digit (
		.dividend  (val_q),
		.base      (base_q),
		.quotient  (quot),
		.remainder (rem)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign can_load  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign km1       = k_q - CNT_W'(1);
	assign op_digits = op_q inside {OP_UDEC, OP_SDEC, OP_HEX, OP_BIN};
	assign emitting  = state_q inside {S_CMD, S_RAW, S_SIGN, S_DIG};
	assign cmd_only  = !((op_q == OP_RAW) || (op_q == OP_SDEC) ||
	                   (op_digits && (cnt_q != '0)));

	assign cnt_sat   = ({1'b0, in_item.digit_count} > 6'(MAX_DIGITS)) ?
	                   6'(MAX_DIGITS) : {1'b0, in_item.digit_count};
	assign addr_calc = {2'd0, in_item.column} - 8'd1 +
	                   ((in_item.line == 2'd1) ? 8'd0 : LINE2_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			k_q         <= '0;
		end else begin
			if (can_load) begin
				out_valid_q <= emitting;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						k_q     <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (k_q == cnt_q) begin
						state_q <= S_CMD;
					end else begin
						k_q <= k_q + CNT_W'(1);
					end
				end
				S_CMD: begin
					if (can_load) begin
						out_q.is_data    <= 1'b0;
						out_q.bus_byte   <= addr_q | CMD_SET_ADDR;
						out_q.last       <= cmd_only;
						if (op_q == OP_RAW) begin
							state_q <= S_RAW;
						end else if (op_q == OP_SDEC) begin
							state_q <= S_SIGN;
						end else if (!cmd_only) begin
							state_q <= S_DIG;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RAW: begin
					if (can_load) begin
						out_q.is_data  <= 1'b1;
						out_q.bus_byte <= val_q[7:0];
						out_q.last     <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				S_SIGN: begin
					if (can_load) begin
						out_q.is_data  <= 1'b1;
						out_q.bus_byte <= neg_q ? CHAR_MINUS : CHAR_PLUS;
						out_q.last     <= (cnt_q == '0);
						state_q        <= (cnt_q == '0) ? S_IDLE : S_DIG;
					end
				end
				S_DIG: begin
					if (can_load) begin
						out_q.is_data  <= 1'b1;
						out_q.bus_byte <= digit_char(digits_q[km1[IDX_W-1:0]]);
						out_q.last     <= (k_q == CNT_W'(1));
						k_q            <= km1;
						if (k_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request fields captured at acceptance; the digit loop then walks the value.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_item.operation;
			addr_q <= addr_calc;
			neg_q  <= (in_item.operation == OP_SDEC) && in_item.value[15];
			if ((in_item.operation == OP_SDEC) && in_item.value[15]) begin
				val_q <= ~in_item.value + 16'd1;
			end else begin
				val_q <= in_item.value;
			end
			case (in_item.operation)
				OP_HEX:  base_q <= BASE_HEX;
				OP_BIN:  base_q <= BASE_BIN;
				default: base_q <= BASE_DEC;
			endcase
			if (in_item.operation inside {OP_UDEC, OP_SDEC, OP_HEX, OP_BIN}) begin
				cnt_q <= CNT_W'(cnt_sat);
			end else begin
				cnt_q <= '0;
			end
		end else if ((state_q == S_DIV) && (k_q != cnt_q)) begin
			digits_q[k_q[IDX_W-1:0]] <= rem;
			val_q <= quot;
		end
	end

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_DIV)
		else $error("accepted item did not start digit extraction");

	a_div_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> k_q <= cnt_q)
		else $error("digit index ran past digit count");

	a_dig_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIG |-> k_q != '0)
		else $error("digit emit with no digits left");

endmodule
